// ===== rtl/cptp_pkg.sv =====
// Package for the class priority task pool.
// Holds the beat and entry types, the sizing constants and the state encoding.
// No dependencies; cptp_ctrl, cptp_datapath and the top level import it.
package cptp_pkg;

  localparam int POOL_ENTRIES = 64;
  localparam int CLASS_COUNT  = 8;
  localparam int IDX_W        = $clog2(POOL_ENTRIES);
  localparam int CNT_W        = $clog2(POOL_ENTRIES + 1);

  // Minus one in Q8.8. Only priorities strictly above this may be taken.
  localparam logic signed [15:0] PRIO_FLOOR = -16'sd256;

  localparam logic ACTION_INSERT = 1'b0;
  localparam logic ACTION_TAKE   = 1'b1;

  localparam logic [1:0] STATUS_OK   = 2'd0;
  localparam logic [1:0] STATUS_NONE = 2'd1;
  localparam logic [1:0] STATUS_FULL = 2'd2;

  typedef struct packed {
    logic               action;
    logic [2:0]         task_class;
    logic signed [15:0] task_priority;
    logic [6:0]         copy_count;
  } req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [31:0]        taken_id;
    logic signed [15:0] taken_priority;
    logic [31:0]        next_id_out;
  } rsp_t;

  typedef struct packed {
    logic [2:0]         cls;
    logic signed [15:0] prio;
    logic [31:0]        id;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INSERT,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic insert_step;
    logic scan_step;
    logic commit;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic start_take;
    logic start_skip;
    logic insert_done;
    logic scan_last;
    logic out_free;
  } dp_status_t;

endpackage

// ===== rtl/cptp_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies.
module cptp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/cptp_ctrl.sv =====
// Controller state machine for the class priority task pool.
// Depends on cptp_pkg; drives the datapath through dp_cmd_t.
module cptp_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_stall,
  input  cptp_pkg::dp_status_t st,
  output cptp_pkg::dp_cmd_t    cmd
);

  import cptp_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (req_valid) begin
          if (st.start_take) begin
            state_next = ST_SCAN;
          end else if (st.start_skip) begin
            state_next = ST_DONE;
          end else begin
            state_next = ST_INSERT;
          end
        end
      end
      ST_INSERT: begin
        if (st.insert_done) begin
          state_next = ST_DONE;
        end
      end
      ST_SCAN: begin
        if (st.scan_last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (st.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd             = '0;
    req_stall       = (state != ST_IDLE);
    cmd.capture     = (state == ST_IDLE) && req_valid;
    cmd.insert_step = (state == ST_INSERT);
    cmd.scan_step   = (state == ST_SCAN);
    cmd.commit      = (state == ST_DONE) && st.out_free;
  end

endmodule

// ===== rtl/cptp_datapath.sv =====
// Datapath of the class priority task pool: valid bits, entry RAM, id counter,
// the running best of a take scan and the result register.
// Depends on cptp_pkg and cptp_ram.
module cptp_datapath (
  input  logic                 clk,
  input  logic                 rst,
  input  cptp_pkg::req_t       req,
  input  cptp_pkg::dp_cmd_t    cmd,
  output cptp_pkg::dp_status_t st,
  output logic                 rsp_valid,
  input  logic                 rsp_stall,
  output cptp_pkg::rsp_t       rsp
);

  import cptp_pkg::*;

  req_t                  req_q;
  logic                  refused;
  logic [POOL_ENTRIES-1:0] valid_bits;
  logic [CNT_W-1:0]      free_cnt;
  logic [CNT_W-1:0]      placed;
  logic [IDX_W-1:0]      scan_idx;
  logic [31:0]           id_counter;

  logic                  rd_pending;
  logic                  rd_vbit;
  logic [IDX_W-1:0]      rd_idx;
  logic [ENTRY_W-1:0]    rd_word;
  entry_t                rd_entry;
  entry_t                wr_entry;

  logic                  best_found;
  logic [IDX_W-1:0]      best_idx;
  logic signed [15:0]    best_prio;
  logic [31:0]           best_id;

  logic                  refuse_now;
  logic                  insert_hit;
  logic                  qualifies;
  logic                  better;
  logic                  take_hit;
  rsp_t                  result;

  // Decisions on the incoming beat, taken while the pool is quiet.
  assign refuse_now = (32'(req.task_class) >= CLASS_COUNT) ||
                      (32'(req.copy_count) > 32'(free_cnt));

  assign insert_hit = !valid_bits[scan_idx];

  assign st.start_take  = (req.action == ACTION_TAKE);
  assign st.start_skip  = refuse_now || (req.copy_count == '0);
  assign st.insert_done = insert_hit &&
                          ((32'(placed) + 32'd1) == 32'(req_q.copy_count));
  assign st.scan_last   = (scan_idx == IDX_W'(POOL_ENTRIES - 1));
  assign st.out_free    = !rsp_valid || !rsp_stall;

  assign wr_entry = '{cls: req_q.task_class, prio: req_q.task_priority, id: id_counter};

  cptp_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (POOL_ENTRIES)
  ) u_entries (
    .clk     (clk),
    .wr_en   (cmd.insert_step && insert_hit),
    .wr_addr (scan_idx),
    .wr_data (wr_entry),
    .rd_en   (cmd.scan_step),
    .rd_addr (scan_idx),
    .rd_data (rd_word)
  );

  assign rd_entry = entry_t'(rd_word);

  assign qualifies = rd_pending && rd_vbit && (rd_entry.cls == req_q.task_class) &&
                     (rd_entry.prio > PRIO_FLOOR);
  assign better    = !best_found || (rd_entry.prio > best_prio) ||
                     ((rd_entry.prio == best_prio) && (rd_entry.id < best_id));

  assign take_hit = (req_q.action == ACTION_TAKE) && best_found;

  always_comb begin
    result             = '0;
    result.next_id_out = id_counter;
    if (req_q.action == ACTION_TAKE) begin
      if (best_found) begin
        result.status         = STATUS_OK;
        result.taken_id       = best_id;
        result.taken_priority = best_prio;
      end else begin
        result.status = STATUS_NONE;
      end
    end else begin
      result.status = refused ? STATUS_FULL : STATUS_OK;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_bits <= '0;
      free_cnt   <= CNT_W'(POOL_ENTRIES);
      id_counter <= '0;
      rd_pending <= 1'b0;
      best_found <= 1'b0;
      rsp_valid  <= 1'b0;
      placed     <= '0;
      scan_idx   <= '0;
    end else begin
      rd_pending <= cmd.scan_step;
      if (cmd.capture) begin
        placed     <= '0;
        scan_idx   <= '0;
        best_found <= 1'b0;
      end
      if (cmd.insert_step) begin
        scan_idx <= scan_idx + IDX_W'(1);
        if (insert_hit) begin
          valid_bits[scan_idx] <= 1'b1;
          free_cnt             <= free_cnt - CNT_W'(1);
          id_counter           <= id_counter + 32'd1;
          placed               <= placed + CNT_W'(1);
        end
      end
      if (cmd.scan_step) begin
        scan_idx <= scan_idx + IDX_W'(1);
      end
      if (qualifies && better) begin
        best_found <= 1'b1;
      end
      if (cmd.commit) begin
        rsp_valid <= 1'b1;
        if (take_hit) begin
          valid_bits[best_idx] <= 1'b0;
          free_cnt             <= free_cnt + CNT_W'(1);
        end
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_q   <= req;
      refused <= refuse_now;
    end
    if (cmd.scan_step) begin
      rd_idx  <= scan_idx;
      rd_vbit <= valid_bits[scan_idx];
    end
    if (qualifies && better) begin
      best_idx  <= rd_idx;
      best_prio <= rd_entry.prio;
      best_id   <= rd_entry.id;
    end
    if (cmd.commit) begin
      rsp <= result;
    end
  end

endmodule

// ===== rtl/class_priority_task_pool.sv =====
// Top level of the class priority task pool.
// Depends on cptp_pkg, cptp_ctrl, cptp_datapath and, through it, cptp_ram.
//
// The block keeps a pool of POOL_ENTRIES task entries, each tagged with a
// class, a signed Q8.8 priority and a sequential 32-bit id. A request beat on
// the req channel either inserts copy_count copies of one task into the
// lowest free slots, or takes the entry of one class with the highest priority
// above minus one, the smaller id winning a tie. Every request beat gives
// exactly one response beat on the rsp channel.
// Both channels use valid and stall; a beat moves when valid is high and
// stall is low. The block takes one request at a time: req_stall is high from
// the accepting edge until the response has been loaded into the output
// register. An insert walks the slots once, one slot a cycle, until the last
// copy is placed; a refused or empty insert skips the walk and goes straight
// to the response. A take reads every entry from the entry RAM, one read a
// cycle, and then finishes the last compare in a drain state before its
// response is loaded into the output register.
// The output register lets a new request be accepted while a response still
// waits; a stalled response holds, and finished work waits for it to leave.
// Synchronous reset clears all valid bits and the id counter at once, so the
// pool is empty and ready in the cycle after reset with no clearing pass.
module class_priority_task_pool (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  cptp_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output cptp_pkg::rsp_t rsp
);

  import cptp_pkg::*;

  // Command and status buses between the sequencer and the datapath.
  dp_cmd_t    cmd;
  dp_status_t st;

  cptp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .st        (st),
    .cmd       (cmd)
  );

  cptp_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd       (cmd),
    .st        (st),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

endmodule
